[rtl/pwir_pkg.sv]
// Package for the per-worker interval reservation calendar.
// Holds request codes, default sizes and shared types; no dependencies.
package pwir_pkg;

   localparam int DefNumWorkers = 16;
   localparam int DefMaxMarks   = 16;
   localparam int DefTimeBits   = 24;

   localparam int ReqTypeBits = 2;
   localparam int WorkerBits  = 4;
   localparam int TaskBits    = 16;
   localparam int DurBits     = 16;
   localparam int FieldTime   = 24;

   typedef enum logic [ReqTypeBits-1:0] {
      REQ_CLEAR   = 2'd0,
      REQ_FIND    = 2'd1,
      REQ_RESERVE = 2'd2,
      REQ_QUERY   = 2'd3
   } req_kind_type;

endpackage

[rtl/pwir_mem.sv]
// Breakpoint store: one time word and one task word per slot, all workers.
// Depends on pwir_pkg. One write and one registered read per cycle.
module pwir_mem
   import pwir_pkg::*;
#(
   parameter int Depth    = DefNumWorkers * DefMaxMarks,
   parameter int TimeBits = DefTimeBits
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [TimeBits-1:0]      wr_time,
   input  logic [TaskBits-1:0]      wr_task,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [TimeBits-1:0]      rd_time,
   output logic [TaskBits-1:0]      rd_task
);

   logic [TimeBits+TaskBits-1:0] store [Depth];
   logic [TimeBits+TaskBits-1:0] rd_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store[wr_addr] <= {wr_task, wr_time};
      end
      rd_ff <= store[rd_addr];
   end

   assign rd_time = rd_ff[TimeBits-1:0];
   assign rd_task = rd_ff[TimeBits+TaskBits-1:TimeBits];

endmodule

[rtl/per_worker_interval_reservation.sv]
// Top level of the per-worker interval reservation calendar.
// Depends on pwir_pkg and pwir_mem.
//
// Usage: one request item enters on the req_ channel and produces exactly
// one result item on the rsp_ channel. Requests: clear all lists, find the
// first free interval long enough for a duration, reserve a task at a start
// time, or ask which task covers a frame.
// Sequencing: a sequencer walks the addressed worker's breakpoint list one
// slot per step through the breakpoint store (one registered read at a
// time). A busy or out-of-range slot passes ST_RD and ST_EVAL; a slot that
// must be compared with its successor also passes ST_RDNEXT and ST_EVNEXT.
// A reserve scans the same way, then shifts the tail one slot at a time
// (ST_SHRD, ST_SHWR) to open room, once or twice, and writes in ST_PUT.
// Clear zeroes every list count at once and goes straight to ST_DONE.
// Throughput: one request at a time; req_tready is high only while the
// sequencer is idle and the result register is empty.
// Reset: every list count goes to zero; store contents stay undefined and
// are never read below the count. No clearing pass is needed.
// Stall: the result waits in the rsp_ register until rsp_tready; the block
// takes no new item meanwhile.
module per_worker_interval_reservation
   import pwir_pkg::*;
#(
   parameter int NUM_WORKERS = DefNumWorkers,
   parameter int MAX_MARKS   = DefMaxMarks,
   parameter int TIME_BITS   = DefTimeBits
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   // req_type[1:0], worker_index[5:2], now_time[29:6], when_time[53:30],
   // when_is_now[54], duration[70:55], task_id[86:71], zero fill to 88
   input  logic [87:0]   req_tdata,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   // success[0], interval_start[24:1], interval_end[48:25], open_ended[49],
   // planned_task[65:50], table_full[66], zero fill to 72
   output logic [71:0]   rsp_tdata
);

   localparam int WIdx    = (NUM_WORKERS > 1) ? $clog2(NUM_WORKERS) : 1;
   localparam int MIdx    = $clog2(MAX_MARKS);
   localparam int CntBits = $clog2(MAX_MARKS + 1);
   localparam int Depth   = NUM_WORKERS * MAX_MARKS;
   localparam int AddrBits = $clog2(Depth);
   localparam logic [TIME_BITS:0] TimeMax = {1'b0, {TIME_BITS{1'b1}}};

   typedef enum logic [3:0] {
      ST_IDLE, ST_START, ST_SEED, ST_RD, ST_EVAL, ST_RDNEXT, ST_EVNEXT,
      ST_SHRD, ST_SHWR, ST_PUT, ST_DONE
   } state_type;

   // unpack request, narrowing fixed-width fields to TIME_BITS
   logic [ReqTypeBits-1:0] f_req;
   logic [WorkerBits-1:0]  f_worker;
   logic [TIME_BITS-1:0]   f_now, f_when;
   logic                   f_isnow;
   logic [DurBits-1:0]     f_dur;
   logic [TaskBits-1:0]    f_task;
   assign f_req    = req_tdata[1:0];
   assign f_worker = req_tdata[5:2];
   assign f_now    = TIME_BITS'(req_tdata[29:6]);
   assign f_when   = TIME_BITS'(req_tdata[53:30]);
   assign f_isnow  = req_tdata[54];
   assign f_dur    = req_tdata[70:55];
   assign f_task   = req_tdata[86:71];

   state_type             state_ff, state_in;
   req_kind_type          kind_ff, kind_in;
   logic [WIdx-1:0]       wk_ff, wk_in;
   logic [TIME_BITS-1:0]  now_ff, now_in, when_ff, when_in, end_ff, end_in;
   logic [DurBits-1:0]    dur_ff, dur_in;
   logic [TaskBits-1:0]   task_ff, task_in;
   logic [CntBits-1:0]    n_ff, n_in;
   logic [CntBits-1:0]    i_ff, i_in;       // slot under scan / shift pointer
   logic [CntBits-1:0]    pos_ff, pos_in;   // insertion position
   logic [TIME_BITS-1:0]  st_ff, st_in;     // time of current slot
   logic [TaskBits-1:0]   sk_ff, sk_in;     // task of current slot
   logic [TIME_BITS-1:0]  pt_ff, pt_in;     // pending insert time
   logic [TaskBits-1:0]   pk_ff, pk_in;     // pending insert task
   logic                  two_ff, two_in;   // second insert still to do
   logic [CntBits-1:0]    cnt_ff [NUM_WORKERS];
   logic                  cnt_we, cnt_clr;
   logic [CntBits-1:0]    cnt_wv;
   logic                  vld_ff, vld_in;
   logic [71:0]           rsp_ff, rsp_in;

   // result fields
   logic                  r_ok, r_open;
   logic [TIME_BITS-1:0]  r_s;

   // store port
   logic                  m_we;
   logic [CntBits-1:0]    m_wslot, m_rslot;
   logic [TIME_BITS-1:0]  m_wt, m_rt;
   logic [TaskBits-1:0]   m_wk, m_rk;
   logic [AddrBits-1:0]   m_wa, m_ra;

   assign m_wa = AddrBits'(wk_ff * MAX_MARKS) + AddrBits'(m_wslot[MIdx-1:0]);
   assign m_ra = AddrBits'(wk_ff * MAX_MARKS) + AddrBits'(m_rslot[MIdx-1:0]);

   pwir_mem #(.Depth(Depth), .TimeBits(TIME_BITS)) u_mem (
      .clock   (clock),
      .wr_en   (m_we),
      .wr_addr (m_wa),
      .wr_time (m_wt),
      .wr_task (m_wk),
      .rd_addr (m_ra),
      .rd_time (m_rt),
      .rd_task (m_rk)
   );

   assign req_tready = (state_ff == ST_IDLE) && !vld_ff;
   assign rsp_tvalid = vld_ff;
   assign rsp_tdata  = rsp_ff;

   logic [TIME_BITS-1:0] earliest, s_eff;
   logic [TIME_BITS:0]   end_sum, gap;
   logic                 last_slot;
   assign earliest  = f_isnow ? f_now : f_when;
   assign end_sum   = {1'b0, when_ff} + {{(TIME_BITS+1-DurBits){1'b0}}, dur_ff};
   assign last_slot = (i_ff + 1'b1) >= n_ff;
   assign s_eff     = (st_ff < when_ff) ? when_ff : st_ff;
   assign gap       = {1'b0, m_rt} - {1'b0, s_eff};

   always_comb begin
      state_in = state_ff;  kind_in = kind_ff;  wk_in = wk_ff;
      now_in = now_ff;  when_in = when_ff;  end_in = end_ff;
      dur_in = dur_ff;  task_in = task_ff;  n_in = n_ff;  i_in = i_ff;
      pos_in = pos_ff;  st_in = st_ff;  sk_in = sk_ff;  pt_in = pt_ff;
      pk_in = pk_ff;  two_in = two_ff;  vld_in = vld_ff;  rsp_in = rsp_ff;
      cnt_we = 1'b0;  cnt_clr = 1'b0;  cnt_wv = n_ff;
      m_we = 1'b0;  m_wslot = i_ff;  m_rslot = i_ff;  m_wt = pt_ff;  m_wk = pk_ff;
      r_ok = 1'b0;  r_open = 1'b0;  r_s = '0;
      if (vld_ff && rsp_tready) begin
         vld_in = 1'b0;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid && req_tready) begin
               kind_in = req_kind_type'(f_req);
               wk_in   = WIdx'(f_worker);
               now_in  = f_now;
               when_in = (f_req == REQ_FIND) ? earliest : f_when;
               dur_in  = f_dur;
               task_in = f_task;
               state_in = ST_START;
               if (f_req == REQ_CLEAR) begin
                  cnt_clr  = 1'b1;
                  r_ok     = 1'b1;
                  state_in = ST_DONE;
               end else if (32'(f_worker) >= NUM_WORKERS) begin
                  state_in = ST_DONE;
               end else if (f_req == REQ_FIND &&
                            (f_task == '0 || earliest < f_now)) begin
                  state_in = ST_DONE;
               end else if (f_req == REQ_RESERVE &&
                            (f_task == '0 || f_dur == '0 || f_when < f_now)) begin
                  state_in = ST_DONE;
               end
               rsp_in = '0;
               rsp_in[0] = r_ok;
            end
         end
         ST_START: begin
            n_in = cnt_ff[wk_ff];
            i_in = '0;
            end_in = end_sum[TIME_BITS-1:0];
            if (cnt_ff[wk_ff] == '0) begin
               if (kind_ff == REQ_FIND) begin
                  r_ok = 1'b1;  r_s = when_ff;  r_open = 1'b1;
                  state_in = ST_DONE;
               end else if (kind_ff == REQ_QUERY) begin
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_SEED;
               end
            end else begin
               state_in = ST_RD;
            end
            if (state_in == ST_DONE) begin
               rsp_in = '0;
               rsp_in[0] = r_ok;  rsp_in[FieldTime:1] = FieldTime'(r_s);
               rsp_in[49] = r_open;
            end
         end
         ST_SEED: begin
            m_we = 1'b1;  m_wslot = '0;  m_wt = now_ff;  m_wk = '0;
            n_in = CntBits'(1);
            cnt_we = 1'b1;  cnt_wv = CntBits'(1);
            state_in = ST_RD;
         end
         ST_RD: begin
            if (kind_ff == REQ_RESERVE && end_sum > TimeMax) begin
               rsp_in = '0;
               state_in = ST_DONE;
            end else if (i_ff >= n_ff) begin
               rsp_in = '0;
               state_in = ST_DONE;
            end else begin
               m_rslot = i_ff;
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            st_in = m_rt;  sk_in = m_rk;
            if (kind_ff != REQ_QUERY && m_rk != '0) begin
               i_in = i_ff + 1'b1;
               state_in = ST_RD;
            end else if (kind_ff == REQ_QUERY && m_rt > when_ff) begin
               i_in = i_ff + 1'b1;
               state_in = ST_RD;
            end else if (last_slot) begin
               rsp_in = '0;
               if (kind_ff == REQ_FIND) begin
                  rsp_in[0] = 1'b1;
                  rsp_in[FieldTime:1] = FieldTime'((m_rt < when_ff) ? when_ff : m_rt);
                  rsp_in[49] = 1'b1;
                  state_in = ST_DONE;
               end else if (kind_ff == REQ_QUERY) begin
                  rsp_in[0] = (m_rk != '0);
                  rsp_in[65:50] = m_rk;
                  state_in = ST_DONE;
               end else if (when_ff < m_rt) begin
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_EVNEXT;   // open slot: fit checked there
               end
            end else begin
               m_rslot  = i_ff + 1'b1;
               state_in = ST_RDNEXT;
            end
         end
         ST_RDNEXT: begin
            // hold the next slot's address so its word is still there
            m_rslot  = i_ff + 1'b1;
            state_in = ST_EVNEXT;
         end
         ST_EVNEXT: begin
            // m_rt holds next slot time unless the current slot is the last
            rsp_in = '0;
            state_in = ST_RD;
            i_in = i_ff + 1'b1;
            unique case (kind_ff)
               REQ_FIND: begin
                  if (m_rt >= s_eff && gap >= {{(TIME_BITS+1-DurBits){1'b0}}, dur_ff}) begin
                     rsp_in[0] = 1'b1;
                     rsp_in[FieldTime:1] = FieldTime'(s_eff);
                     rsp_in[48:25] = FieldTime'(m_rt);
                     state_in = ST_DONE;
                  end
               end
               REQ_QUERY: begin
                  if (when_ff < m_rt) begin
                     rsp_in[0] = (sk_ff != '0);
                     rsp_in[65:50] = sk_ff;
                     state_in = ST_DONE;
                  end
               end
               default: begin
                  if (when_ff >= st_ff && (last_slot || end_ff < m_rt)) begin
                     if (n_ff + ((when_ff == st_ff) ? 1 : 2) > MAX_MARKS) begin
                        rsp_in[66] = 1'b1;
                        state_in = ST_DONE;
                     end else begin
                        pos_in = i_ff + 1'b1;
                        if (when_ff == st_ff) begin
                           m_we = 1'b1;  m_wslot = i_ff;
                           m_wt = st_ff;  m_wk = task_ff;
                           pt_in = end_ff;  pk_in = '0;  two_in = 1'b0;
                        end else begin
                           pt_in = when_ff;  pk_in = task_ff;  two_in = 1'b1;
                        end
                        i_in = n_ff;
                        state_in = ST_SHRD;
                     end
                  end
               end
            endcase
         end
         ST_SHRD: begin
            // move slot i-1 up to i, down to pos
            if (i_ff == pos_ff) begin
               state_in = ST_PUT;
            end else begin
               m_rslot = i_ff - 1'b1;
               state_in = ST_SHWR;
            end
         end
         ST_SHWR: begin
            m_we = 1'b1;  m_wslot = i_ff;  m_wt = m_rt;  m_wk = m_rk;
            i_in = i_ff - 1'b1;
            state_in = ST_SHRD;
         end
         ST_PUT: begin
            m_we = 1'b1;  m_wslot = pos_ff;  m_wt = pt_ff;  m_wk = pk_ff;
            n_in = n_ff + 1'b1;
            if (two_ff) begin
               two_in = 1'b0;  pt_in = end_ff;  pk_in = '0;
               pos_in = pos_ff + 1'b1;
               i_in = n_ff + 1'b1;
               state_in = ST_SHRD;
            end else begin
               cnt_we = 1'b1;  cnt_wv = n_ff + 1'b1;
               rsp_in = '0;  rsp_in[0] = 1'b1;
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!vld_ff) begin
               vld_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         vld_ff   <= 1'b0;
         for (int w = 0; w < NUM_WORKERS; w++) cnt_ff[w] <= '0;
      end else begin
         state_ff <= state_in;
         vld_ff   <= vld_in;
         if (cnt_clr) begin
            for (int w = 0; w < NUM_WORKERS; w++) cnt_ff[w] <= '0;
         end else if (cnt_we) begin
            cnt_ff[wk_ff] <= cnt_wv;
         end
      end
      kind_ff <= kind_in;  wk_ff <= wk_in;  now_ff <= now_in;  when_ff <= when_in;
      end_ff <= end_in;  dur_ff <= dur_in;  task_ff <= task_in;  n_ff <= n_in;
      i_ff <= i_in;  pos_ff <= pos_in;  st_ff <= st_in;  sk_ff <= sk_in;
      pt_ff <= pt_in;  pk_ff <= pk_in;  two_ff <= two_in;  rsp_ff <= rsp_in;
   end

endmodule
